// File: hw/rtl/gcvbs_pkg.sv
// Shared types and constants for the garbage-collection victim selector.
package gcvbs_pkg;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned DIV_STEPS = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_PER_BLOCK = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT     = 4'd1;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  localparam logic STATUS_FOUND    = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [9:0]  block_index;
    logic        block_busy;
    logic [31:0] cook_until;
    logic [10:0] valid_pages;
    logic [31:0] current_time;
    logic [31:0] random_value;
  } in_req_t;

  typedef struct packed {
    logic [9:0] victim_block;
    logic       select_status;
  } out_rsp_t;

  // One block record as held in the table memory.
  typedef struct packed {
    logic        busy;
    logic [31:0] cook;
    logic [10:0] valid;
  } blk_rec_t;

endpackage

// File: hw/rtl/gc_victim_block_selector.sv
// Greedy garbage-collection victim selector: record table, two scans and tie-break remainder.
//
// Input channel (in_valid / in_stall / in_req): cmd write stores one block
// record (busy, cook-until, valid count) and gives no result.
// cmd select scans blocks 0..min(block_count,NUM_BLOCKS)-1 and returns one
// result on out_valid / out_stall / out_rsp: the victim block, or status
// no-space with victim 0.
// A select makes two passes over the table memory at one read a cycle, with
// the bit-serial remainder unit running between them. in_stall is high while
// a select is in progress; writes are taken at one per cycle.
// The result sits in an output register, so the next request is accepted
// while it waits; a select that finishes while that register is still held
// by a stalled receiver waits until it frees up.
// cfg port (cfg_valid / cfg_ready / cfg_index / cfg_wdata) sets
// pages_per_block (index 0) and block_count (index 1); cfg_ready is always high.
// Reset sets pages_per_block to 64, block_count to 1024 and empties the
// pipeline; table contents are undefined until written, no clearing pass.
module gc_victim_block_selector #(
  parameter int unsigned NUM_BLOCKS = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  gcvbs_pkg::in_req_t                  in_req,
  output logic                                out_valid,
  input  logic                                out_stall,
  output gcvbs_pkg::out_rsp_t                 out_rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gcvbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gcvbs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import gcvbs_pkg::*;

  localparam int unsigned AW = $clog2(NUM_BLOCKS);
  localparam int unsigned TW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned NW = (TW > 11) ? TW : 11;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN1 = 5'b00010,
    S_DIV   = 5'b00100,
    S_SCAN2 = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [10:0]   ppb_r, ppb_nxt;
  logic [10:0]   bcnt_r, bcnt_nxt;
  logic [31:0]   now_r, now_nxt;
  logic [31:0]   rand_r, rand_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [10:0]   min_r, min_nxt;
  logic [TW-1:0] ties_r, ties_nxt;
  logic [TW-1:0] seen_r, seen_nxt;
  logic [TW-1:0] k_r, k_nxt;
  logic          found_r, found_nxt;
  logic [AW-1:0] victim_r, victim_nxt;
  logic          status_r, status_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_rsp_t      out_rsp_r, out_rsp_nxt;

  logic          in_acc;
  logic          wr_en;
  logic          scanning;
  logic          issue;
  logic          scan_end;
  logic          slot_free;
  logic          elig;
  logic          div_start;
  logic          div_done;
  logic [TW-1:0] div_rem;
  logic [NW-1:0] bcnt_ext;
  blk_rec_t      wr_rec;
  blk_rec_t      rd_rec;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign slot_free = !out_valid_r || !out_stall;

  assign wr_en = in_acc && (in_req.cmd == CMD_WRITE) &&
                 (NW'(in_req.block_index) < NW'(NUM_BLOCKS));
  assign wr_rec = '{busy: in_req.block_busy, cook: in_req.cook_until,
                    valid: in_req.valid_pages};

  assign scanning = (state_r == S_SCAN1) || (state_r == S_SCAN2);
  assign issue    = scanning && (cnt_r < n_r);
  assign scan_end = scanning && !issue && !rd_vld_r;
  assign elig     = !rd_rec.busy && (rd_rec.cook <= now_r);
  assign bcnt_ext = NW'(bcnt_r);

  gcvbs_table #(
    .DEPTH (NUM_BLOCKS),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_req.block_index)),
    .wr_data (wr_rec),
    .rd_en   (issue),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (rd_rec)
  );

  gcvbs_mod #(
    .TW (TW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rand_r),
    .divisor  (ties_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  // configuration registers
  always_comb begin
    ppb_nxt  = ppb_r;
    bcnt_nxt = bcnt_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PAGES_PER_BLOCK) begin
        ppb_nxt = cfg_wdata;
      end else if (cfg_index == CFG_BLOCK_COUNT) begin
        bcnt_nxt = cfg_wdata;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    rand_nxt      = rand_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = issue;
    rd_idx_nxt    = cnt_r[AW-1:0];
    min_nxt       = min_r;
    ties_nxt      = ties_r;
    seen_nxt      = seen_r;
    k_nxt         = k_r;
    found_nxt     = found_r;
    victim_nxt    = victim_r;
    status_nxt    = status_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;

    if (issue) begin
      cnt_nxt = cnt_r + NW'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_req.cmd == CMD_SELECT)) begin
          now_nxt  = in_req.current_time;
          rand_nxt = in_req.random_value;
          n_nxt    = (bcnt_ext > NW'(NUM_BLOCKS)) ? NW'(NUM_BLOCKS) : bcnt_ext;
          cnt_nxt  = '0;
          min_nxt  = ppb_r;
          ties_nxt = '0;
          state_nxt = S_SCAN1;
        end
      end
      S_SCAN1: begin
        if (rd_vld_r && elig) begin
          if (rd_rec.valid < min_r) begin
            min_nxt  = rd_rec.valid;
            ties_nxt = TW'(1);
          end else if (rd_rec.valid == min_r) begin
            ties_nxt = ties_r + TW'(1);
          end
        end
        if (scan_end) begin
          if ((min_r >= ppb_r) || (ties_r == '0)) begin
            status_nxt = STATUS_NO_SPACE;
            victim_nxt = '0;
            state_nxt  = S_DONE;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          k_nxt     = div_rem;
          cnt_nxt   = '0;
          seen_nxt  = '0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN2;
        end
      end
      S_SCAN2: begin
        // keep streaming after the hit; found_r freezes the pick
        if (rd_vld_r && elig && (rd_rec.valid == min_r) && !found_r) begin
          if (seen_r == k_r) begin
            found_nxt  = 1'b1;
            victim_nxt = rd_idx_r;
          end
          seen_nxt = seen_r + TW'(1);
        end
        if (scan_end) begin
          status_nxt = STATUS_FOUND;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{victim_block: 10'(victim_r), select_status: status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ppb_r       <= 11'd64;
      bcnt_r      <= 11'd1024;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ppb_r       <= ppb_nxt;
      bcnt_r      <= bcnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    rand_r    <= rand_nxt;
    n_r       <= n_nxt;
    cnt_r     <= cnt_nxt;
    rd_idx_r  <= rd_idx_nxt;
    min_r     <= min_nxt;
    ties_r    <= ties_nxt;
    seen_r    <= seen_nxt;
    k_r       <= k_nxt;
    victim_r  <= victim_nxt;
    status_r  <= status_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  // the tie-break index always lands inside the tie count
  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_done) |-> (div_rem < ties_r))
    else $error("tie-break remainder not below tie count");

  // second pass must meet the k-th minimum block
  a_second_pass_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN2 && scan_end) |-> found_r)
    else $error("second pass ended without a victim");

  // no-space results carry block zero
  a_no_space_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rsp_r.select_status == STATUS_NO_SPACE) |->
      (out_rsp_r.victim_block == 10'd0))
    else $error("no-space result with nonzero victim");

  // a loaded result never overwrites one still held by the receiver
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && out_stall) |=> (state_r == S_DONE))
    else $error("result left done state while output slot busy");

endmodule

// File: hw/rtl/gcvbs_table.sv
// Block record table: single-port-write, registered-read synchronous memory.
module gcvbs_table #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  gcvbs_pkg::blk_rec_t  wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output gcvbs_pkg::blk_rec_t  rd_data
);
  import gcvbs_pkg::*;

  blk_rec_t mem [DEPTH];
  blk_rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/gcvbs_mod.sv
// Iterative restoring remainder unit: 32-bit dividend mod narrow divisor, one bit a cycle.
module gcvbs_mod #(
  parameter int unsigned TW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [TW-1:0] divisor,
  output logic          done,
  output logic [TW-1:0] rem
);
  import gcvbs_pkg::*;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [31:0]   dsh_r, dsh_nxt;
  logic [TW-1:0] rem_r, rem_nxt;
  logic [TW-1:0] dvs_r, dvs_nxt;
  logic [TW:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dsh_nxt  = dsh_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, dsh_r[31]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(DIV_STEPS);
      dsh_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // partial remainder stays below divisor, so trial < 2*divisor
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = TW'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[TW-1:0];
      end
      dsh_nxt = {dsh_r[30:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dsh_r <= dsh_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
